// ----- rtl/core/spl_pkg.sv -----
// Shared types and constants for the sorted price level table.
// Depends on nothing; every other file refers to it by scoped names.
package spl_pkg;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_ERASE  = 3'd1,
    ACT_LOOKUP = 3'd2,
    ACT_READ   = 3'd3,
    ACT_ACCUM  = 3'd4
  } action_e;

  localparam logic [1:0] CFG_SORT_DESC = 2'd0;
  localparam logic [1:0] CFG_CAPACITY  = 2'd1;
  localparam logic [10:0] CAP_RESET    = 11'd1024;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [9:0]  position;
  } spl_in_t;

  typedef struct packed {
    logic        ok;
    logic [10:0] level_index;
    logic [31:0] level_price;
    logic [31:0] level_quantity;
    logic        evicted;
    logic [10:0] entry_count;
  } spl_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_POS_RD, ST_POS_CMP, ST_DECIDE,
    ST_WORST_CMP, ST_SHD_RD, ST_SHD_WR, ST_SHU_RD, ST_SHU_WR, ST_RESP
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_START, OP_SCAN_RD, OP_SCAN_HIT, OP_SCAN_NEXT, OP_SCAN_END,
    OP_FOUND_RES, OP_POS_RD, OP_POS_TAKE, OP_WORST_RD, OP_SHD_INIT,
    OP_SHD_INIT_EV, OP_SHD_RD, OP_SHD_WR, OP_PUT, OP_SHU_INIT, OP_SHU_RD,
    OP_SHU_WR, OP_SHU_FIN, OP_ACC_WR
  } dp_op_e;

  typedef struct packed {
    logic [2:0] action;
    logic       found;
    logic       full;
    logic       cnt_zero;
    logic       pos_ok;
    logic       idx_end;
    logic       hit;
    logic       worst_better;
    logic       at_lb;
  } spl_stat_t;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
  } spl_cmd_t;

endpackage

// ----- rtl/core/spl_dp.sv -----
// Datapath of the sorted price level table: level memories, scan and shift
// counters, result registers. Depends on spl_pkg.
module spl_dp #(
  parameter int MAX_LEVELS = 1024,
  parameter int PRICE_BITS = 32,
  parameter int QTY_BITS   = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spl_pkg::dp_op_e    op_i,
  input  spl_pkg::spl_in_t   in_data_i,
  input  logic               sort_desc_i,
  input  logic [10:0]        cap_i,
  output spl_pkg::spl_stat_t stat_o,
  output spl_pkg::spl_out_t  res_o
);

  localparam int AW   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int CW   = $clog2(MAX_LEVELS + 1);
  localparam int CMPW = (CW > 11) ? CW : 11;

  logic [PRICE_BITS-1:0] p_mem [MAX_LEVELS];
  logic [QTY_BITS-1:0]   q_mem [MAX_LEVELS];

  logic [2:0]            act_q;
  logic [PRICE_BITS-1:0] key_q, fp_q, rp_q, rd_p_q;
  logic [QTY_BITS-1:0]   qin_q, fq_q, rq_q, rd_q_q;
  logic [9:0]            pos_q;
  logic [CW-1:0]         idx_q, lb_q, cnt_q;
  logic                  found_q, ok_q, ev_q;

  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [PRICE_BITS-1:0] wr_p;
  logic [QTY_BITS-1:0]   wr_q;
  logic [QTY_BITS:0]     sum;
  logic [QTY_BITS-1:0]   sat;
  logic [CMPW-1:0]       cap_eff, cnt_ext;
  logic                  full;

  assign sum     = {1'b0, fq_q} + {1'b0, qin_q};
  assign sat     = sum[QTY_BITS] ? {QTY_BITS{1'b1}} : sum[QTY_BITS-1:0];
  assign cnt_ext = CMPW'(cnt_q);
  assign cap_eff = (cap_i == 11'd0) ? CMPW'(1) : CMPW'(cap_i);
  assign full    = (cnt_ext >= cap_eff) || (cnt_q == CW'(MAX_LEVELS));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(idx_q);
    wr_en   = 1'b0;
    wr_addr = AW'(idx_q);
    wr_p    = rd_p_q;
    wr_q    = rd_q_q;
    case (op_i)
      spl_pkg::OP_SCAN_RD, spl_pkg::OP_SHU_RD: begin
        rd_en = 1'b1;
      end
      spl_pkg::OP_POS_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(pos_q);
      end
      spl_pkg::OP_WORST_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(cnt_q - CW'(1));
      end
      spl_pkg::OP_SHD_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx_q - CW'(1));
      end
      spl_pkg::OP_SHD_WR: begin
        wr_en = 1'b1;
      end
      spl_pkg::OP_SHU_WR: begin
        wr_en   = 1'b1;
        wr_addr = AW'(idx_q - CW'(1));
      end
      spl_pkg::OP_PUT: begin
        wr_en   = 1'b1;
        wr_addr = AW'(lb_q);
        wr_p    = key_q;
        wr_q    = qin_q;
      end
      spl_pkg::OP_ACC_WR: begin
        wr_en   = 1'b1;
        wr_addr = AW'(lb_q);
        wr_p    = key_q;
        wr_q    = sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      p_mem[wr_addr] <= wr_p;
      q_mem[wr_addr] <= wr_q;
    end
    if (rd_en) begin
      rd_p_q <= p_mem[rd_addr];
      rd_q_q <= q_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      found_q <= 1'b0;
      ok_q    <= 1'b0;
      ev_q    <= 1'b0;
    end else begin
      case (op_i)
        spl_pkg::OP_START: begin
          found_q <= 1'b0;
          ok_q    <= 1'b0;
          ev_q    <= 1'b0;
        end
        spl_pkg::OP_SCAN_HIT:  found_q <= (rd_p_q == key_q);
        spl_pkg::OP_FOUND_RES: ok_q    <= (act_q == spl_pkg::ACT_LOOKUP);
        spl_pkg::OP_POS_TAKE, spl_pkg::OP_SHD_INIT, spl_pkg::OP_SHU_INIT,
        spl_pkg::OP_ACC_WR: ok_q <= 1'b1;
        spl_pkg::OP_SHD_INIT_EV: begin
          ok_q <= 1'b1;
          ev_q <= 1'b1;
        end
        spl_pkg::OP_PUT:     if (!ev_q) cnt_q <= cnt_q + CW'(1);
        spl_pkg::OP_SHU_FIN: cnt_q <= cnt_q - CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      spl_pkg::OP_START: begin
        act_q <= in_data_i.action;
        key_q <= PRICE_BITS'(in_data_i.price);
        qin_q <= QTY_BITS'(in_data_i.quantity);
        pos_q <= in_data_i.position;
        idx_q <= '0;
        lb_q  <= '0;
        rp_q  <= '0;
        rq_q  <= '0;
      end
      spl_pkg::OP_SCAN_HIT: begin
        lb_q <= idx_q;
        fp_q <= rd_p_q;
        fq_q <= rd_q_q;
      end
      spl_pkg::OP_SCAN_NEXT, spl_pkg::OP_SHU_WR: idx_q <= idx_q + CW'(1);
      spl_pkg::OP_SCAN_END: lb_q <= idx_q;
      spl_pkg::OP_FOUND_RES: begin
        rp_q <= fp_q;
        rq_q <= fq_q;
      end
      spl_pkg::OP_POS_TAKE: begin
        rp_q <= rd_p_q;
        rq_q <= rd_q_q;
      end
      spl_pkg::OP_SHD_INIT: begin
        idx_q <= cnt_q;
        rp_q  <= key_q;
        rq_q  <= qin_q;
      end
      spl_pkg::OP_SHD_INIT_EV: begin
        idx_q <= cnt_q - CW'(1);
        rp_q  <= key_q;
        rq_q  <= qin_q;
      end
      spl_pkg::OP_SHD_WR: idx_q <= idx_q - CW'(1);
      spl_pkg::OP_SHU_INIT: begin
        idx_q <= lb_q + CW'(1);
        rp_q  <= key_q;
        rq_q  <= '0;
      end
      spl_pkg::OP_ACC_WR: begin
        rp_q <= key_q;
        rq_q <= sat;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.action       = act_q;
    stat_o.found        = found_q;
    stat_o.full         = full;
    stat_o.cnt_zero     = (cnt_q == '0);
    stat_o.pos_ok       = CMPW'(pos_q) < cnt_ext;
    stat_o.idx_end      = (idx_q >= cnt_q);
    stat_o.hit          = sort_desc_i ? !(rd_p_q > key_q) : !(rd_p_q < key_q);
    stat_o.worst_better = sort_desc_i ? (key_q > rd_p_q) : (key_q < rd_p_q);
    stat_o.at_lb        = (idx_q == lb_q);
  end

  always_comb begin
    res_o.ok             = ok_q;
    res_o.level_index    = (act_q == spl_pkg::ACT_READ) ? 11'(pos_q) : 11'(lb_q);
    res_o.level_price    = 32'(rp_q);
    res_o.level_quantity = 32'(rq_q);
    res_o.evicted        = ev_q;
    res_o.entry_count    = 11'(cnt_q);
  end

endmodule

// ----- rtl/core/spl_ctrl.sv -----
// Controller of the sorted price level table: sequences scan, shift and
// result steps of the datapath. Depends on spl_pkg.
module spl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [2:0]         in_action_i,
  input  logic               out_free_i,
  input  spl_pkg::spl_stat_t stat_i,
  output logic               in_ready_o,
  output spl_pkg::spl_cmd_t  cmd_o
);

  spl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_action_i == spl_pkg::ACT_READ) state_d = spl_pkg::ST_POS_RD;
          else if (in_action_i > spl_pkg::ACT_ACCUM) state_d = spl_pkg::ST_RESP;
          else state_d = spl_pkg::ST_SCAN_RD;
        end
      end
      spl_pkg::ST_POS_RD:
        state_d = stat_i.pos_ok ? spl_pkg::ST_POS_CMP : spl_pkg::ST_RESP;
      spl_pkg::ST_POS_CMP: state_d = spl_pkg::ST_RESP;
      spl_pkg::ST_SCAN_RD:
        state_d = stat_i.idx_end ? spl_pkg::ST_DECIDE : spl_pkg::ST_SCAN_CMP;
      spl_pkg::ST_SCAN_CMP:
        state_d = stat_i.hit ? spl_pkg::ST_DECIDE : spl_pkg::ST_SCAN_RD;
      spl_pkg::ST_DECIDE: begin
        state_d = spl_pkg::ST_RESP;
        case (stat_i.action)
          spl_pkg::ACT_INSERT: begin
            if (!stat_i.found && stat_i.full && !stat_i.cnt_zero)
              state_d = spl_pkg::ST_WORST_CMP;
            else if (!stat_i.found && !stat_i.full) state_d = spl_pkg::ST_SHD_RD;
          end
          spl_pkg::ACT_ERASE:
            if (stat_i.found) state_d = spl_pkg::ST_SHU_RD;
          spl_pkg::ACT_ACCUM:
            if (!stat_i.found && !stat_i.full) state_d = spl_pkg::ST_SHD_RD;
          default: ;
        endcase
      end
      spl_pkg::ST_WORST_CMP:
        state_d = stat_i.worst_better ? spl_pkg::ST_SHD_RD : spl_pkg::ST_RESP;
      spl_pkg::ST_SHD_RD:
        state_d = stat_i.at_lb ? spl_pkg::ST_RESP : spl_pkg::ST_SHD_WR;
      spl_pkg::ST_SHD_WR: state_d = spl_pkg::ST_SHD_RD;
      spl_pkg::ST_SHU_RD:
        state_d = stat_i.idx_end ? spl_pkg::ST_RESP : spl_pkg::ST_SHU_WR;
      spl_pkg::ST_SHU_WR: state_d = spl_pkg::ST_SHU_RD;
      spl_pkg::ST_RESP:
        if (out_free_i) state_d = spl_pkg::ST_IDLE;
      default: state_d = spl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == spl_pkg::ST_IDLE);
    cmd_o.op      = spl_pkg::OP_NONE;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      spl_pkg::ST_IDLE:
        if (in_valid_i) cmd_o.op = spl_pkg::OP_START;
      spl_pkg::ST_POS_RD:
        if (stat_i.pos_ok) cmd_o.op = spl_pkg::OP_POS_RD;
      spl_pkg::ST_POS_CMP: cmd_o.op = spl_pkg::OP_POS_TAKE;
      spl_pkg::ST_SCAN_RD:
        cmd_o.op = stat_i.idx_end ? spl_pkg::OP_SCAN_END : spl_pkg::OP_SCAN_RD;
      spl_pkg::ST_SCAN_CMP:
        cmd_o.op = stat_i.hit ? spl_pkg::OP_SCAN_HIT : spl_pkg::OP_SCAN_NEXT;
      spl_pkg::ST_DECIDE: begin
        case (stat_i.action)
          spl_pkg::ACT_INSERT: begin
            if (stat_i.found) cmd_o.op = spl_pkg::OP_FOUND_RES;
            else if (stat_i.full && !stat_i.cnt_zero) cmd_o.op = spl_pkg::OP_WORST_RD;
            else if (!stat_i.full) cmd_o.op = spl_pkg::OP_SHD_INIT;
          end
          spl_pkg::ACT_ERASE:
            if (stat_i.found) cmd_o.op = spl_pkg::OP_SHU_INIT;
          spl_pkg::ACT_LOOKUP:
            if (stat_i.found) cmd_o.op = spl_pkg::OP_FOUND_RES;
          spl_pkg::ACT_ACCUM: begin
            if (stat_i.found) cmd_o.op = spl_pkg::OP_ACC_WR;
            else if (!stat_i.full) cmd_o.op = spl_pkg::OP_SHD_INIT;
          end
          default: ;
        endcase
      end
      spl_pkg::ST_WORST_CMP:
        if (stat_i.worst_better) cmd_o.op = spl_pkg::OP_SHD_INIT_EV;
      spl_pkg::ST_SHD_RD:
        cmd_o.op = stat_i.at_lb ? spl_pkg::OP_PUT : spl_pkg::OP_SHD_RD;
      spl_pkg::ST_SHD_WR: cmd_o.op = spl_pkg::OP_SHD_WR;
      spl_pkg::ST_SHU_RD:
        cmd_o.op = stat_i.idx_end ? spl_pkg::OP_SHU_FIN : spl_pkg::OP_SHU_RD;
      spl_pkg::ST_SHU_WR: cmd_o.op = spl_pkg::OP_SHU_WR;
      spl_pkg::ST_RESP: cmd_o.out_load = out_free_i;
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/sorted_price_level_table_core.sv -----
// Sorted price level table, top level. Uses spl_pkg, spl_ctrl and spl_dp.
// Each item scans entries up to and including the lower bound, then shifts
// entries for an insert, an erase or a new accumulated level; a read goes
// straight to its position. Items are handled one at a time: no new item is
// taken until the result of the last has been loaded into the result register.
// Reset empties the table at once (count zero); no clearing pass is run.
module sorted_price_level_table_core #(
  parameter int MAX_LEVELS = 1024,
  parameter int PRICE_BITS = 32,
  parameter int QTY_BITS   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spl_pkg::spl_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spl_pkg::spl_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [10:0]       cfg_data_i
);

  // Configuration registers. Writes are to be made only while the block is idle;
  // the block itself does not enforce this, and writes are always accepted.
  logic        sort_desc_q;
  logic [10:0] cap_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sort_desc_q <= 1'b0;
      cap_q       <= spl_pkg::CAP_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        spl_pkg::CFG_SORT_DESC: sort_desc_q <= cfg_data_i[0];
        spl_pkg::CFG_CAPACITY:  cap_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  spl_pkg::spl_stat_t stat;
  spl_pkg::spl_cmd_t  cmd;
  spl_pkg::spl_out_t  res;
  logic               out_free;

  // The output register frees as soon as the waiting result transfers.
  assign out_free = !out_valid_o || out_ready_i;

  spl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .out_free_i  (out_free),
    .stat_i      (stat),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  spl_dp #(
    .MAX_LEVELS (MAX_LEVELS),
    .PRICE_BITS (PRICE_BITS),
    .QTY_BITS   (QTY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (cmd.op),
    .in_data_i   (in_data_i),
    .sort_desc_i (sort_desc_q),
    .cap_i       (cap_q),
    .stat_o      (stat),
    .res_o       (res)
  );

  // Result register: holds one finished result until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_data_o <= res;
    end
  end

  // The block is not ready in the cycle after it accepts an item.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // An eviction only comes with a successful insert.
  a_evict_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.evicted || out_data_o.ok))
    else $error("eviction reported without success");

  // The level count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(out_data_o.entry_count) <= MAX_LEVELS))
    else $error("level count beyond table depth");

endmodule

// ----- bench/sorted_price_level_table_core_tb.sv -----
// Self-checking testbench for sorted_price_level_table_core.
// Depends on spl_pkg and the core RTL. It has its own table predictor, random
// traffic with stalls, and configuration writes between phases.
module sorted_price_level_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1024;

  // Predictor and scoreboard. It tracks its own copy of the level table and
  // the two registers, and queues one expected result per accepted transfer.
  class level_table_board;
    logic [31:0]       px [DEPTH];
    logic [31:0]       qt [DEPTH];
    int unsigned       cnt;
    bit                desc;
    logic [10:0]       cap_reg;
    spl_pkg::spl_out_t want_q[$];
    int                errors;
    int                checked;

    function new();
      cnt = 0;
      desc = 1'b0;
      cap_reg = spl_pkg::CAP_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function bit better(logic [31:0] a, logic [31:0] b);
      return desc ? (a > b) : (a < b);
    endfunction

    function void configure(logic [1:0] idx, logic [10:0] val);
      if (idx == spl_pkg::CFG_SORT_DESC) desc = val[0];
      else if (idx == spl_pkg::CFG_CAPACITY) cap_reg = val;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    // Apply one accepted input transfer and queue the result it must produce.
    function void note(spl_pkg::spl_in_t it);
      spl_pkg::spl_out_t r;
      int unsigned       lb;
      int unsigned       cap;
      int unsigned       last;
      bit                found;
      bit                full;
      logic [32:0]       sum;
      r = '0;
      cap = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : cap_reg);
      lb = 0;
      while (lb < cnt && better(px[lb], it.price)) lb++;
      found = (lb < cnt) && (px[lb] == it.price);
      full = (cnt >= cap);
      case (it.action)
        spl_pkg::ACT_INSERT: begin
          r.level_index = 11'(lb);
          if (found) begin
            r.level_price = px[lb];
            r.level_quantity = qt[lb];
          end else if (!full || (cnt > 0 && better(it.price, px[cnt-1]))) begin
            // When full, the worst level falls off the end of the table.
            last = full ? cnt - 1 : cnt;
            for (int i = last; i > lb; i--) begin
              px[i] = px[i-1];
              qt[i] = qt[i-1];
            end
            px[lb] = it.price;
            qt[lb] = it.quantity;
            if (full) r.evicted = 1'b1;
            else cnt++;
            r.ok = 1'b1;
            r.level_price = it.price;
            r.level_quantity = it.quantity;
          end
        end
        spl_pkg::ACT_ERASE: begin
          r.level_index = 11'(lb);
          if (found) begin
            for (int i = lb + 1; i < cnt; i++) begin
              px[i-1] = px[i];
              qt[i-1] = qt[i];
            end
            cnt--;
            r.ok = 1'b1;
            r.level_price = it.price;
          end
        end
        spl_pkg::ACT_LOOKUP: begin
          r.level_index = 11'(lb);
          if (found) begin
            r.ok = 1'b1;
            r.level_price = px[lb];
            r.level_quantity = qt[lb];
          end
        end
        spl_pkg::ACT_READ: begin
          r.level_index = 11'(it.position);
          if (it.position < cnt) begin
            r.ok = 1'b1;
            r.level_price = px[it.position];
            r.level_quantity = qt[it.position];
          end
        end
        spl_pkg::ACT_ACCUM: begin
          r.level_index = 11'(lb);
          if (found) begin
            // Quantities saturate rather than wrap.
            sum = {1'b0, qt[lb]} + {1'b0, it.quantity};
            qt[lb] = sum[32] ? '1 : sum[31:0];
            r.ok = 1'b1;
            r.level_price = it.price;
            r.level_quantity = qt[lb];
          end else if (!full) begin
            for (int i = cnt; i > lb; i--) begin
              px[i] = px[i-1];
              qt[i] = qt[i-1];
            end
            px[lb] = it.price;
            qt[lb] = it.quantity;
            cnt++;
            r.ok = 1'b1;
            r.level_price = it.price;
            r.level_quantity = it.quantity;
          end
        end
        default: ;
      endcase
      r.entry_count = 11'(cnt);
      want_q.insert(want_q.size(), r);
    endfunction

    function void check(spl_pkg::spl_out_t got);
      spl_pkg::spl_out_t w;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected result transfer %p", $time, got);
        errors++;
        return;
      end
      w = want_q.pop_front();
      checked++;
      if (got.ok !== w.ok || got.level_index !== w.level_index ||
          got.level_price !== w.level_price || got.level_quantity !== w.level_quantity ||
          got.evicted !== w.evicted || got.entry_count !== w.entry_count) begin
        $display("%0t: mismatch expected %p actual %p", $time, w, got);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  spl_pkg::spl_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  spl_pkg::spl_out_t out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [10:0]       cfg_data = '0;

  level_table_board board = new();
  bit          calm = 1'b0;      // no idling on either side in the final phase
  int          hold_request = 0; // long receiver hold-off requested by the stimulus
  int          sent = 0;

  always #5 clk = ~clk;

  sorted_price_level_table_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Result side. Every result transfer is checked against the oldest
  // prediction, and ready is dropped in random bursts or for one long
  // hold-off whenever the stimulus asks for it.
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) board.check(out_data);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 10);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one item, maybe after a random gap, and hand it to the predictor
  // on the edge where the transfer happens.
  task automatic send(spl_pkg::spl_in_t it);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    board.note(it);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    // Then wait for the block to settle back to idle.
    repeat (8) @(posedge clk);
  endtask

  // Register writes happen only with the table idle and nothing in flight.
  task automatic cfg_write(logic [1:0] idx, logic [10:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.configure(idx, val);
    cfg_valid <= 1'b0;
  endtask

  function automatic spl_pkg::spl_in_t mk(logic [2:0] act, logic [31:0] p, logic [31:0] q,
                                          logic [9:0] pos);
    spl_pkg::spl_in_t it;
    it.action = act;
    it.price = p;
    it.quantity = q;
    it.position = pos;
    return it;
  endfunction

  // Random item. Prices mostly come from a narrow band so that hits, duplicates
  // and erases of present levels are common; a few are fully random.
  function automatic spl_pkg::spl_in_t rand_item(logic [31:0] base, int band);
    spl_pkg::spl_in_t it;
    int unsigned      pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) it.action = spl_pkg::ACT_INSERT;
    else if (pick < 50) it.action = spl_pkg::ACT_ACCUM;
    else if (pick < 68) it.action = spl_pkg::ACT_ERASE;
    else if (pick < 82) it.action = spl_pkg::ACT_LOOKUP;
    else if (pick < 96) it.action = spl_pkg::ACT_READ;
    else it.action = 3'($urandom_range(spl_pkg::ACT_ACCUM + 1, 7));
    case ($urandom_range(0, 9))
      0: it.price = $urandom;
      1: it.price = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: it.price = base + $urandom_range(0, band);
    endcase
    it.quantity = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                              : $urandom;
    it.position = ($urandom_range(0, 3) == 0) ? 10'($urandom)
                                              : 10'($urandom_range(0, board.cnt + 2));
    return it;
  endfunction

  initial begin
    logic [31:0] base;
    logic [10:0] cap;
    int          band;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: field extremes, every action, duplicates, saturation,
    // unused action codes and reads past the count.
    send(mk(spl_pkg::ACT_INSERT, 32'h0, 32'h0, 10'd0));
    send(mk(spl_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd0));
    send(mk(spl_pkg::ACT_INSERT, 32'd100, 32'd5, 10'd0));
    send(mk(spl_pkg::ACT_INSERT, 32'd100, 32'd9, 10'd0));
    send(mk(spl_pkg::ACT_LOOKUP, 32'd100, 32'd0, 10'd0));
    send(mk(spl_pkg::ACT_LOOKUP, 32'd50, 32'd0, 10'd0));
    send(mk(spl_pkg::ACT_READ, 32'd0, 32'd0, 10'd2));
    send(mk(spl_pkg::ACT_READ, 32'd0, 32'd0, 10'h3FF));
    send(mk(spl_pkg::ACT_ACCUM, 32'd100, 32'hFFFF_FFF0, 10'd0));
    send(mk(spl_pkg::ACT_ACCUM, 32'd200, 32'd7, 10'd0));
    send(mk(spl_pkg::ACT_ERASE, 32'd200, 32'd0, 10'd0));
    send(mk(spl_pkg::ACT_ERASE, 32'd200, 32'd0, 10'd0));
    for (int a = spl_pkg::ACT_ACCUM + 1; a < 8; a++)
      send(mk(3'(a), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF));

    // Capacity below the count: the table is full, so only better prices
    // get in by evicting the worst level, and accumulate cannot add levels.
    cfg_write(spl_pkg::CFG_CAPACITY, 11'd2);
    send(mk(spl_pkg::ACT_INSERT, 32'd50, 32'd1, 10'd0));
    send(mk(spl_pkg::ACT_INSERT, 32'hFFFF_FFFE, 32'd1, 10'd0));
    send(mk(spl_pkg::ACT_ACCUM, 32'd60, 32'd1, 10'd0));
    send(mk(spl_pkg::ACT_ACCUM, 32'd0, 32'd7, 10'd0));
    // A capacity of zero behaves as one.
    cfg_write(spl_pkg::CFG_CAPACITY, 11'd0);
    send(mk(spl_pkg::ACT_INSERT, 32'd1, 32'd3, 10'd0));
    // Flip the order with levels still held; nothing is re-sorted.
    cfg_write(spl_pkg::CFG_SORT_DESC, 11'd1);
    send(mk(spl_pkg::ACT_INSERT, 32'd70, 32'd2, 10'd0));
    send(mk(spl_pkg::ACT_LOOKUP, 32'd100, 32'd0, 10'd0));
    send(mk(spl_pkg::ACT_READ, 32'd0, 32'd0, 10'd0));

    // Random phases over several settings, including capacity 1 and values
    // above the table depth. The band of prices bounds how far the table grows.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: cap = 11'd1;
        1: cap = 11'd4;
        2: cap = 11'd2047;
        3: cap = 11'd16;
        4: cap = 11'd1024;
        5: cap = 11'd3;
        6: cap = 11'($urandom_range(5, 40));
        default: cap = 11'd8;
      endcase
      cfg_write(spl_pkg::CFG_CAPACITY, cap);
      cfg_write(spl_pkg::CFG_SORT_DESC, 11'($urandom_range(0, 1)));
      base = $urandom;
      band = (cap > 40) ? 120 : 2 * cap + 4;
      if (ph == 7) calm = 1'b1;
      for (int n = 0; n < 78; n++) begin
        // Fill-up case: the receiver sits still while items keep coming.
        if (ph == 1 && n == 20) hold_request = 300;
        // The sender waits for every outstanding result once.
        if (ph == 3 && n == 40) begin
          in_valid <= 1'b0;
          while (board.pending() != 0) @(posedge clk);
        end
        send(rand_item(base, band));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Ran %0d items over eight capacity and order settings, %0d results checked.",
             sent, board.checked);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
